/* src/swm_pkg.sv */
package swm_pkg;

  localparam int WINDOW_MAX = 1024;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 11;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int POS_MOD    = 2 * WINDOW_MAX;
  localparam int POS_W      = $clog2(POS_MOD);
  localparam int OCC_W      = $clog2(WINDOW_MAX + 1);
  localparam int ENTRY_W    = SAMPLE_W + POS_W;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch the incoming request
    logic rd_en;     // issue a deque read
    logic rd_new;    // 1: read newest entry, 0: read oldest entry
    logic pop_old;   // drop the oldest entry
    logic pop_new;   // drop the newest entry
    logic append;    // push the latched sample
    logic load_out;  // move the head value into the output register
  } swm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic occ_empty;
    logic occ_single;
    logic expired;   // oldest entry read back is out of the window
    logic smaller;   // newest entry read back is below the sample
    logic emit;      // this sample produces a result
    logic out_free;  // output register can take a value this cycle
  } swm_status_t;

endpackage

/* src/swm_ram.sv */
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/swm_ctrl.sv */
module swm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  swm_pkg::swm_status_t sts,
  output swm_pkg::swm_cmd_t    cmd
);
  import swm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXP  = 5'b00010,
    S_POP  = 5'b00100,
    S_APP  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.occ_empty) begin
            state_nxt = S_APP;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_EXP;
          end
        end
      end
      S_EXP: begin
        if (sts.expired) begin
          cmd.pop_old = 1'b1;
          if (sts.occ_single) begin
            state_nxt = S_APP;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_new = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_POP: begin
        if (sts.smaller) begin
          cmd.pop_new = 1'b1;
          if (sts.occ_single) begin
            state_nxt = S_APP;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_new = 1'b1;
          end
        end else begin
          state_nxt = S_APP;
        end
      end
      S_APP: begin
        cmd.append = 1'b1;
        if (sts.emit) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/swm_dp.sv */
module swm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic [swm_pkg::SAMPLE_W-1:0] in_tdata,
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [swm_pkg::SAMPLE_W-1:0] out_tdata,
  output logic                         out_tlast,
  input  swm_pkg::swm_cmd_t            cmd,
  output swm_pkg::swm_status_t         sts
);
  import swm_pkg::*;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
    ring_next = (i == PTR_W'(WINDOW_MAX - 1)) ? '0 : i + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] i);
    ring_prev = (i == '0) ? PTR_W'(WINDOW_MAX - 1) : i - PTR_W'(1);
  endfunction

  logic [CFG_W-1:0]    cfg_window_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                last_r;
  logic                head_new_r;
  logic [PTR_W-1:0]    oldest_r, oldest_nxt;
  logic [PTR_W-1:0]    newest_r, newest_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [OCC_W-1:0]    fill_r, fill_inc;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_last_r;

  logic [OCC_W-1:0]    win;
  logic                full;
  logic                clear;
  logic [PTR_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [SAMPLE_W-1:0] rd_value;
  logic [POS_W-1:0]    rd_pos;
  logic [POS_W:0]      age_wide;
  logic [POS_W-1:0]    age;

  always_comb begin
    if (cfg_window_r == '0) begin
      win = OCC_W'(1);
    end else if (32'(cfg_window_r) > 32'(WINDOW_MAX)) begin
      win = OCC_W'(WINDOW_MAX);
    end else begin
      win = OCC_W'(cfg_window_r);
    end
  end

  assign full     = (occ_r == OCC_W'(WINDOW_MAX));
  assign clear    = cmd.load_out & last_r;
  assign rd_value = rd_entry[SAMPLE_W-1:0];
  assign rd_pos   = rd_entry[ENTRY_W-1:SAMPLE_W];

  // position distance modulo the position ring
  always_comb begin
    if (pos_r >= rd_pos) begin
      age_wide = {1'b0, pos_r} - {1'b0, rd_pos};
    end else begin
      age_wide = {1'b0, pos_r} + (POS_W+1)'(POS_MOD) - {1'b0, rd_pos};
    end
    age = age_wide[POS_W-1:0];
  end

  assign fill_inc = (fill_r < win) ? fill_r + OCC_W'(1) : win;

  always_comb begin
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    occ_nxt    = occ_r;
    if (cmd.pop_old) begin
      oldest_nxt = ring_next(oldest_r);
      occ_nxt    = occ_r - OCC_W'(1);
    end
    if (cmd.pop_new) begin
      newest_nxt = ring_prev(newest_r);
      occ_nxt    = occ_r - OCC_W'(1);
    end
    if (cmd.append && !full) begin
      newest_nxt = ring_next(newest_r);
      occ_nxt    = occ_r + OCC_W'(1);
    end
    if (clear) begin
      oldest_nxt = '0;
      newest_nxt = '0;
      occ_nxt    = '0;
    end
  end

  // read address follows the pointers as they stand after this cycle
  assign rd_addr = cmd.rd_new ? ring_prev(newest_nxt) : oldest_nxt;

  swm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_MAX)
  ) u_deque (
    .clk   (clk),
    .we    (cmd.append & ~full),
    .waddr (newest_r),
    .wdata ({pos_r, sample_r}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_window_r <= CFG_W'(1);
      oldest_r     <= '0;
      newest_r     <= '0;
      occ_r        <= '0;
      pos_r        <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_window_r <= cfg_wr_data;
      end
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      occ_r    <= occ_nxt;
      if (clear) begin
        pos_r  <= '0;
        fill_r <= '0;
      end else if (cmd.append) begin
        pos_r  <= (pos_r == POS_W'(POS_MOD - 1)) ? '0 : pos_r + POS_W'(1);
        fill_r <= fill_inc;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_tdata;
      last_r   <= in_tlast;
    end
    // an empty deque means the head is the sample being appended now
    if (cmd.append) begin
      head_new_r <= (occ_r == '0);
    end
    if (cmd.load_out) begin
      out_data_r <= head_new_r ? sample_r : rd_value;
      out_last_r <= last_r;
    end
  end

  assign sts.occ_empty  = (occ_r == '0);
  assign sts.occ_single = (occ_r == OCC_W'(1));
  assign sts.expired    = (age >= POS_W'(win));
  assign sts.smaller    = ($signed(rd_value) < $signed(sample_r));
  assign sts.emit       = (fill_inc == win) | last_r;
  assign sts.out_free   = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/sliding_window_max_filter.sv */
// Sliding-window maximum filter over a stream of signed 32-bit samples.
// Input requests arrive on in_tvalid/in_tready with the sample in in_tdata
// and in_tlast marking the final sample of a stream. Once window-size
// samples of a stream have arrived, each sample yields the maximum over the
// last window-size samples on out_tdata; the final sample always yields a
// result (maximum of the whole stream if it was short) with out_tlast set,
// and then clears the stream state. cfg_wr_en/cfg_wr_data set the window
// size (0 acts as 1, above 1024 acts as 1024); write it only while idle.
// Operation: one sample is processed at a time by a small controller walking
// a deque memory with one write port and one read port. Each sample is
// accepted; unless the deque is empty, the oldest entry is read and dropped
// while it is out of the window, then the newest entries below the sample
// are read and dropped; the sample is appended and, if it yields a result,
// the head value is loaded into the result register once that register is
// free. Each sample enters and leaves the deque once. If the receiver
// stalls, the block finishes the next sample up to its result and waits
// there with in_tready low. Reset (rst_n low, synchronous) empties the
// deque, clears the stream position and sets the window size to 1.
module sliding_window_max_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wr_data,   // window_size
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0] in_tdata,      // [31:0] sample
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [swm_pkg::SAMPLE_W-1:0] out_tdata,     // [31:0] window_max
  output logic                         out_tlast
);
  import swm_pkg::*;

  swm_cmd_t    cmd;
  swm_status_t sts;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
